FILE: hw/rtl/bdeq_pkg.sv
// Shared types and codes for the bounded double-ended queue.
package bdeq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } bdeq_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } bdeq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESULT
    } bdeq_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } bdeq_ctl_t;

endpackage

FILE: hw/rtl/bounded_double_ended_queue_top.sv
// m_tvalid rises once an accepted command item has passed through the execute
//   state of the controller and reached its result state.
// One item at a time: no new command item is accepted until the result has been
//   taken; the controller steps through its accept, execute (ring memory access,
//   registered read) and result hand-off steps.
// Reset: aresetn low clears head, count and controller; storage is not cleared.
// Top level of the bounded double-ended queue.
module bounded_double_ended_queue_top
    import bdeq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int M_TDATA_W = ((36 + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] cmd, [33:2] push_value, rest zero
    input  logic [39:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [33:2] popped_value, then fill_count, is_empty_flag,
    // is_full_flag, rest zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    bdeq_ctl_t          ctl;
    bdeq_status_t       status;
    logic signed [31:0] popped_value;
    logic [CNT_W-1:0]   fill_count;
    logic               is_empty_flag;
    logic               is_full_flag;

    bdeq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    bdeq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .cmd           (bdeq_cmd_t'(s_tdata[1:0])),
        .push_value    (s_tdata[33:2]),
        .status        (status),
        .popped_value  (popped_value),
        .fill_count    (fill_count),
        .is_empty_flag (is_empty_flag),
        .is_full_flag  (is_full_flag)
    );

    assign m_tdata = M_TDATA_W'({is_full_flag, is_empty_flag, fill_count,
                                 popped_value, status});

endmodule

FILE: hw/rtl/bdeq_ctrl.sv
// Controller state machine: sequences accept, execute and result delivery.
module bdeq_ctrl
    import bdeq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output bdeq_ctl_t ctl
);

    bdeq_state_t state_reg;
    bdeq_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                ctl.exec   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (ctl.exec && !s_tready && !m_tvalid))
        else $error("accepted item not executed next cycle");

    a_exec_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec |=> m_tvalid)
        else $error("execute not followed by a result");
`endif

endmodule

FILE: hw/rtl/bdeq_dpath.sv
// Datapath: ring storage, head and count registers, result registers.
module bdeq_dpath
    import bdeq_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IDX_W   = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bdeq_ctl_t          ctl,
    input  bdeq_cmd_t          cmd,
    input  logic signed [31:0] push_value,
    output bdeq_status_t       status,
    output logic signed [31:0] popped_value,
    output logic [CNT_W-1:0]   fill_count,
    output logic               is_empty_flag,
    output logic               is_full_flag
);

    localparam int SUM_W = CNT_W + 1;

    logic signed [31:0] mem [CAPACITY];

    bdeq_cmd_t          cmd_reg;
    logic signed [31:0] value_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    bdeq_status_t       status_reg;
    bdeq_status_t       status_next;
    logic               pop_ok_reg;
    logic               pop_ok_next;
    logic signed [31:0] rd_data_reg;

    logic               full;
    logic               empty;
    logic [IDX_W-1:0]   head_dec;
    logic [IDX_W-1:0]   head_inc;
    logic [SUM_W-1:0]   back_sum;
    logic [SUM_W-1:0]   last_sum;
    logic [IDX_W-1:0]   back_slot;
    logic [IDX_W-1:0]   last_slot;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // slot one past the back, and slot of the back entry, both wrapped
    assign back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum  = back_sum - 1'b1;
    assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
                       IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);
    assign last_slot = (last_sum >= SUM_W'(CAPACITY)) ?
                       IDX_W'(last_sum - SUM_W'(CAPACITY)) : IDX_W'(last_sum);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        pop_ok_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = head_dec;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        unique case (cmd_reg)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    status_next = STAT_OVERFLOW;
                end else begin
                    wr_en      = ctl.exec;
                    wr_addr    = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    status_next = STAT_OVERFLOW;
                end else begin
                    wr_en      = ctl.exec;
                    wr_addr    = back_slot;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    status_next = STAT_UNDERFLOW;
                end else begin
                    rd_en       = ctl.exec;
                    rd_addr     = head_reg;
                    pop_ok_next = 1'b1;
                    head_next   = head_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    status_next = STAT_UNDERFLOW;
                end else begin
                    rd_en       = ctl.exec;
                    rd_addr     = last_slot;
                    pop_ok_next = 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg   <= cmd;
            value_reg <= push_value;
        end
        if (ctl.exec) begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (ctl.exec) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status        = status_reg;
    assign popped_value  = pop_ok_reg ? rd_data_reg : '0;
    assign fill_count    = count_reg;
    assign is_empty_flag = empty;
    assign is_full_flag  = full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= IDX_W'(CAPACITY - 1))
        else $error("head index out of range");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.exec |=> (count_reg == $past(count_reg)
                      || count_reg == $past(count_reg) + 1'b1
                      || count_reg == $past(count_reg) - 1'b1))
        else $error("fill count moved by more than one");
`endif

endmodule

FILE: test/tb_bounded_double_ended_queue_top.sv
// Self-checking testbench for the bounded double-ended queue top level.
module tb_bounded_double_ended_queue_top;
    import bdeq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int OUT_W       = ((36 + FILL_W + 7) / 8) * 8;
    localparam int N_RANDOM    = 1800;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    typedef struct packed {
        bdeq_status_t      status;
        logic [31:0]       popped;
        logic [FILL_W-1:0] fill;
        logic              empty;
        logic              full;
    } deq_result_t;

    typedef struct {
        bdeq_cmd_t   cmd;
        logic [31:0] value;
        int          reps;
        bit          typed;
        deq_result_t want;
    } dir_row_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // typed expectation travels with the item it belongs to
    bit               cur_typed = 1'b0;
    deq_result_t      cur_want  = '0;

    logic [31:0]      ring_mem [DEPTH];
    logic [3:0]       ring_head = '0;
    logic [FILL_W-1:0] ring_fill = '0;

    deq_result_t      pending_results [$];
    dir_row_t         dir_rows [$];
    int               mismatch_count = 0;
    int               stall_cycles = 0;
    int               burst_left = 0;

    bounded_double_ended_queue_top #(.CAPACITY(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic deque_model_step(input bdeq_cmd_t cmd, input logic [31:0] value,
                                    output deq_result_t r);
        logic [3:0] slot;
        r = '0;
        r.status = STAT_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (ring_fill == DEPTH) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    ring_head = ring_head - 4'd1;
                    ring_mem[ring_head] = value;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (ring_fill == DEPTH) begin
                    r.status = STAT_OVERFLOW;
                end else begin
                    slot = ring_head + ring_fill[3:0];
                    ring_mem[slot] = value;
                    ring_fill = ring_fill + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (ring_fill == 0) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    r.popped = ring_mem[ring_head];
                    ring_head = ring_head + 4'd1;
                    ring_fill = ring_fill - 1'b1;
                end
            end
            default: begin
                if (ring_fill == 0) begin
                    r.status = STAT_UNDERFLOW;
                end else begin
                    // low bits of a full count are zero, so minus one wraps to the tail
                    slot = ring_head + ring_fill[3:0] - 4'd1;
                    r.popped = ring_mem[slot];
                    ring_fill = ring_fill - 1'b1;
                end
            end
        endcase
        r.fill  = ring_fill;
        r.empty = (ring_fill == 0);
        r.full  = (ring_fill == DEPTH);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic add_row(input bdeq_cmd_t cmd, input logic [31:0] value, input int reps,
                           input bit typed, input bdeq_status_t st, input logic [31:0] popped,
                           input int fill, input logic empty, input logic full);
        dir_row_t row;
        row.cmd         = cmd;
        row.value       = value;
        row.reps        = reps;
        row.typed       = typed;
        row.want.status = st;
        row.want.popped = popped;
        row.want.fill   = fill[FILL_W-1:0];
        row.want.empty  = empty;
        row.want.full   = full;
        dir_rows.push_back(row);
    endtask

    task automatic send_cmd(input bdeq_cmd_t cmd, input logic [31:0] value, input bit typed,
                            input deq_result_t want);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid  <= 1'b1;
        s_tdata   <= {6'b0, value, cmd};
        cur_typed <= typed;
        cur_want  <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // predict on every accepted command item
    always @(posedge aclk) begin
        deq_result_t r;
        if (aresetn && s_tvalid && s_tready) begin
            deque_model_step(bdeq_cmd_t'(s_tdata[1:0]), s_tdata[33:2], r);
            pending_results.push_back(cur_typed ? cur_want : r);
        end
    end

    always @(posedge aclk) begin
        deq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                check_field("popped_value", want.popped, m_tdata[33:2]);
                check_field("fill_count", 32'(want.fill), 32'(m_tdata[34 +: FILL_W]));
                check_field("is_empty_flag", 32'(want.empty), 32'(m_tdata[34 + FILL_W]));
                check_field("is_full_flag", 32'(want.full), 32'(m_tdata[35 + FILL_W]));
            end
        end
    end

    // receiver: ready steps through a 16-bit pattern, which is redrawn from one of four random kinds
    logic [15:0] rdy_pat = 16'hFFFF;
    int unsigned rdy_tick = 0;
    always @(posedge aclk) begin
        if (rdy_tick % 48 == 0) begin
            case ($urandom_range(0, 3))
                0:       rdy_pat <= '1;
                1:       rdy_pat <= 16'($urandom);
                2:       rdy_pat <= 16'($urandom | $urandom);
                default: rdy_pat <= 16'($urandom & $urandom);
            endcase
        end
        m_tready <= rdy_pat[rdy_tick % 16];
        rdy_tick <= rdy_tick + 1;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        do @(posedge aclk); while (stall_cycles < STALL_LIMIT);
        $display("tb_bounded_double_ended_queue_top: done, errors");
        $finish;
    end

    initial begin
        int          mode;
        bit          push;
        bit          front;
        bdeq_cmd_t   cmd;
        logic [31:0] value;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row(CMD_POP_FRONT,  32'h0,        1,  1, STAT_UNDERFLOW, 32'h0,        0,  1, 0);
        add_row(CMD_POP_BACK,   32'h0,        1,  1, STAT_UNDERFLOW, 32'h0,        0,  1, 0);
        add_row(CMD_PUSH_FRONT, 32'h80000000, 1,  1, STAT_OK,        32'h0,        1,  0, 0);
        add_row(CMD_PUSH_BACK,  32'h7FFFFFFF, 1,  1, STAT_OK,        32'h0,        2,  0, 0);
        add_row(CMD_POP_FRONT,  32'h0,        1,  1, STAT_OK,        32'h80000000, 1,  0, 0);
        add_row(CMD_POP_BACK,   32'h0,        1,  1, STAT_OK,        32'h7FFFFFFF, 0,  1, 0);
        // fill from both ends, head wraps below zero
        add_row(CMD_PUSH_FRONT, 32'hFFFFFFFF, 8,  0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_PUSH_BACK,  32'h00000000, 8,  0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_PUSH_FRONT, 32'h12345678, 1,  1, STAT_OVERFLOW,  32'h0,        16, 0, 1);
        add_row(CMD_PUSH_BACK,  32'hFEDCBA98, 1,  1, STAT_OVERFLOW,  32'h0,        16, 0, 1);
        add_row(CMD_POP_BACK,   32'h0,        3,  0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_PUSH_FRONT, 32'h55555555, 3,  0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_POP_FRONT,  32'h0,        16, 0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_POP_BACK,   32'h0,        1,  1, STAT_UNDERFLOW, 32'h0,        0,  1, 0);
        add_row(CMD_PUSH_BACK,  32'hAAAAAAAA, 20, 0, STAT_OK,        32'h0,        0,  0, 0);
        add_row(CMD_POP_FRONT,  32'h0,        20, 0, STAT_OK,        32'h0,        0,  0, 0);

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                value = dir_rows[i].typed ? dir_rows[i].value : dir_rows[i].value + k;
                send_cmd(dir_rows[i].cmd, value, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        mode = 2;
        for (int n = 0; n < N_RANDOM; n++) begin
            // alternate filling, draining and balanced stretches to hit both bounds
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       push = ($urandom_range(0, 3) != 0);
                1:       push = ($urandom_range(0, 3) == 0);
                default: push = $urandom_range(0, 1);
            endcase
            front = $urandom_range(0, 1);
            if (push) cmd = front ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            else      cmd = front ? CMD_POP_FRONT : CMD_POP_BACK;
            value = $urandom;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h80000000;
                    1:       value = 32'h7FFFFFFF;
                    2:       value = 32'h00000000;
                    default: value = 32'hFFFFFFFF;
                endcase
            end
            send_cmd(cmd, value, 1'b0, '0);
        end

        s_tvalid  <= 1'b0;
        cur_typed <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_bounded_double_ended_queue_top: done, clean");
        end else begin
            $display("tb_bounded_double_ended_queue_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bdeq_pkg.sv
hw/rtl/bdeq_ctrl.sv
hw/rtl/bdeq_dpath.sv
hw/rtl/bounded_double_ended_queue_top.sv
test/tb_bounded_double_ended_queue_top.sv
